@@ hdl/iqdf_pkg.sv @@
// Shared constants, codes and types of the decimating I/Q FIR filter.
`default_nettype none

package iqdf_pkg;

  // Sizes of the filter.
  localparam int MAX_TAPS  = 128;
  localparam int COEF_W    = 18;
  localparam int MAX_FRAME = 4096;

  // Field widths of the channels and the configuration port.
  localparam int MODE_W     = 2;
  localparam int SAMPLE_W   = 24;
  localparam int CIDX_W     = 7;
  localparam int OUT_W      = 32;
  localparam int TAP_CFG_W  = 8;
  localparam int DEC_W      = 9;
  localparam int SPF_W      = 13;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;

  // Derived widths.
  localparam int TAP_AW   = $clog2(MAX_TAPS);
  localparam int TAPCNT_W = $clog2(MAX_TAPS + 1);
  localparam int POS_W    = $clog2(MAX_FRAME);
  localparam int PROD_W   = SAMPLE_W + COEF_W;
  localparam int ACC_W    = PROD_W + TAP_AW + 1;

  // Item modes.
  localparam logic [MODE_W-1:0] MODE_SAMPLE = 2'd0;
  localparam logic [MODE_W-1:0] MODE_LOAD   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_CLEAR  = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_TAP_COUNT   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DECIM       = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_SIZE  = 2'd2;

  // Configuration reset values.
  localparam logic [TAP_CFG_W-1:0] TAP_COUNT_RST  = 8'd127;
  localparam logic [DEC_W-1:0]     DECIM_RST      = 9'd1;
  localparam logic [SPF_W-1:0]     FRAME_SIZE_RST = 13'd256;

  // Status of the decimation phase unit.
  typedef struct packed {
    logic done;
    logic zero;
  } rem_stat_t;

endpackage

`default_nettype wire

@@ hdl/iqdf_if.sv @@
// Valid/ready channel interfaces for the filter's input items and results.
`default_nettype none

interface iqdf_in_if;
  logic                                 valid;
  logic                                 ready;
  logic [iqdf_pkg::MODE_W-1:0]          mode;
  logic [iqdf_pkg::SAMPLE_W-1:0]        sample_i;
  logic [iqdf_pkg::SAMPLE_W-1:0]        sample_q;
  logic [iqdf_pkg::CIDX_W-1:0]          coef_index;
  logic signed [iqdf_pkg::COEF_W-1:0]   coef_value;

  modport source (output valid, mode, sample_i, sample_q, coef_index, coef_value,
                  input ready);
  modport sink   (input valid, mode, sample_i, sample_q, coef_index, coef_value,
                  output ready);
endinterface

interface iqdf_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [iqdf_pkg::OUT_W-1:0]  out_i;
  logic signed [iqdf_pkg::OUT_W-1:0]  out_q;

  modport source (output valid, out_i, out_q, input ready);
  modport sink   (input valid, out_i, out_q, output ready);
endinterface

`default_nettype wire

@@ hdl/iqdf_rem.sv @@
// Bit-serial remainder unit that decides whether a frame position is on the decimation grid.
`default_nettype none

module iqdf_rem (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start_i,
  input  wire logic [iqdf_pkg::POS_W-1:0]    dividend_i,
  input  wire logic [iqdf_pkg::DEC_W-1:0]    divisor_i,
  output iqdf_pkg::rem_stat_t                stat_o
);

  localparam int CNT_W = $clog2(iqdf_pkg::POS_W);

  logic                          busy_q, done_q;
  logic [CNT_W-1:0]              cnt_q;
  logic [iqdf_pkg::POS_W-1:0]    dvd_q;
  logic [iqdf_pkg::DEC_W-1:0]    dvs_q;
  logic [iqdf_pkg::DEC_W-1:0]    rem_q;
  logic [iqdf_pkg::DEC_W:0]      trial;
  logic [iqdf_pkg::DEC_W:0]      diff;
  logic [iqdf_pkg::DEC_W-1:0]    rem_d;

  // One restoring step: shift in the next dividend bit and subtract if it fits.
  always_comb begin
    trial = {rem_q, dvd_q[iqdf_pkg::POS_W-1]};
    diff  = trial - {1'b0, dvs_q};
    if (trial >= {1'b0, dvs_q}) begin
      rem_d = diff[iqdf_pkg::DEC_W-1:0];
    end else begin
      rem_d = trial[iqdf_pkg::DEC_W-1:0];
    end
  end

  // Control of the iteration, one dividend bit per cycle.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CNT_W'(iqdf_pkg::POS_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Operand and partial remainder registers.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dividend_i;
      dvs_q <= divisor_i;
      rem_q <= '0;
    end else if (busy_q) begin
      dvd_q <= {dvd_q[iqdf_pkg::POS_W-2:0], 1'b0};
      rem_q <= rem_d;
    end
  end

  assign stat_o.done = done_q;
  assign stat_o.zero = (rem_q == '0);

endmodule

`default_nettype wire

@@ hdl/iq_decimating_fir.sv @@
// Decimating complex FIR filter: top level with delay and coefficient memories and the MAC sweep.
//
// Items enter on in_ch (valid/ready); a transfer happens when both are high.
// Mode sample writes one I/Q pair into the delay memory; load writes one
// coefficient; clear empties the delay line and restarts the frame. Load,
// clear and the unused mode complete at their transfer and give no result.
// A sample first runs a bit-serial remainder of the frame position by the
// decimation factor. On the grid, one shared sweep reads one delay word and
// one coefficient per cycle from synchronous memories and feeds one
// multiplier per lane; the input frees when the result is loaded into the
// output register. An off-grid sample holds the input only until the phase
// check finishes. One item at a time. Results leave on out_ch from an
// output register. A stalled receiver does not stop the next item from
// entering; only the step that loads the result waits for the output
// register to empty.
// Reset empties the delay line (by a fill count, so no clearing pass is
// needed), restarts the frame and loads the configuration defaults. The
// coefficient memory holds no reset value and must be loaded before use.
// Configuration is written through cfg_we_i, cfg_idx_i, cfg_data_i; users must do it when idle.
`default_nettype none

module iq_decimating_fir (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               cfg_we_i,
  input  wire logic [iqdf_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  wire logic [iqdf_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  iqdf_in_if.sink                                 in_ch,
  iqdf_out_if.source                              out_ch
);

  localparam int SH_W = iqdf_pkg::ACC_W + 2 - iqdf_pkg::COEF_W;
  localparam logic [iqdf_pkg::ACC_W:0] RND =
    (iqdf_pkg::ACC_W + 1)'(1) << (iqdf_pkg::COEF_W - 2);

  typedef enum logic [2:0] {
    S_IDLE,
    S_REM,
    S_MAC,
    S_DRAIN,
    S_FIN
  } state_e;

  // Round half up, drop the fraction bits and saturate to the output width.
  function automatic logic signed [iqdf_pkg::OUT_W-1:0] round_sat(
    input logic signed [iqdf_pkg::ACC_W-1:0] acc
  );
    logic [iqdf_pkg::ACC_W:0]   r;
    logic [SH_W-1:0]            sh;
    logic [SH_W-iqdf_pkg::OUT_W:0] top;
    r   = {acc[iqdf_pkg::ACC_W-1], acc} + RND;
    sh  = r[iqdf_pkg::ACC_W:iqdf_pkg::COEF_W-1];
    top = sh[SH_W-1:iqdf_pkg::OUT_W-1];
    if (top == '0 || top == '1) begin
      return sh[iqdf_pkg::OUT_W-1:0];
    end else if (sh[SH_W-1]) begin
      return {1'b1, {(iqdf_pkg::OUT_W-1){1'b0}}};
    end else begin
      return {1'b0, {(iqdf_pkg::OUT_W-1){1'b1}}};
    end
  endfunction

  state_e                                state_q;

  // Configuration registers.
  logic [iqdf_pkg::TAP_CFG_W-1:0]        tap_cnt_q;
  logic [iqdf_pkg::DEC_W-1:0]            dec_q;
  logic [iqdf_pkg::SPF_W-1:0]            spf_q;

  // Effective settings after clamping.
  logic [iqdf_pkg::TAPCNT_W-1:0]         taps_eff;
  logic [iqdf_pkg::DEC_W-1:0]            dec_eff;
  logic [iqdf_pkg::SPF_W-1:0]            spf_eff;

  // Delay line bookkeeping and frame position.
  logic [iqdf_pkg::TAP_AW-1:0]           wr_ptr_q, newest_q;
  logic [iqdf_pkg::TAPCNT_W-1:0]         fill_q;
  logic [iqdf_pkg::POS_W-1:0]            pos_q;
  logic [iqdf_pkg::POS_W:0]              pos_inc;

  // Sweep counters.
  logic [iqdf_pkg::TAP_AW-1:0]           idx_q, j_q, d_q;
  logic [iqdf_pkg::TAPCNT_W-1:0]         taps_m1;

  // Memories and their registered read data.
  logic [2*iqdf_pkg::SAMPLE_W-1:0]       dly_mem [iqdf_pkg::MAX_TAPS];
  logic signed [iqdf_pkg::COEF_W-1:0]    coef_mem [iqdf_pkg::MAX_TAPS];
  logic [2*iqdf_pkg::SAMPLE_W-1:0]       dly_rd_q;
  logic signed [iqdf_pkg::COEF_W-1:0]    coef_rd_q;

  // MAC pipeline.
  logic                                  rd_vld_q, rd_ok_q, mul_vld_q;
  logic signed [iqdf_pkg::PROD_W-1:0]    prod_i_q, prod_q_q;
  logic signed [iqdf_pkg::ACC_W-1:0]     acc_i_q, acc_q_q;
  logic                                  acc_clr;

  // Output register.
  logic                                  out_vld_q;
  logic signed [iqdf_pkg::OUT_W-1:0]     out_i_q, out_q_q;

  logic                                  accept, sample_acc, load_acc, out_load;
  iqdf_pkg::rem_stat_t                   rem_stat;

  // Clamp the configuration to the ranges the datapath supports.
  always_comb begin
    if (int'(tap_cnt_q) > iqdf_pkg::MAX_TAPS) begin
      taps_eff = iqdf_pkg::TAPCNT_W'(iqdf_pkg::MAX_TAPS);
    end else begin
      taps_eff = iqdf_pkg::TAPCNT_W'(tap_cnt_q);
    end
    dec_eff = (dec_q == '0) ? iqdf_pkg::DEC_W'(1) : dec_q;
    if (spf_q == '0) begin
      spf_eff = iqdf_pkg::SPF_W'(1);
    end else if (int'(spf_q) > iqdf_pkg::MAX_FRAME) begin
      spf_eff = iqdf_pkg::SPF_W'(iqdf_pkg::MAX_FRAME);
    end else begin
      spf_eff = spf_q;
    end
  end

  assign taps_m1    = taps_eff - 1'b1;
  assign pos_inc    = {1'b0, pos_q} + 1'b1;
  assign accept     = in_ch.valid && in_ch.ready;
  assign sample_acc = accept && (in_ch.mode == iqdf_pkg::MODE_SAMPLE);
  assign load_acc   = accept && (in_ch.mode == iqdf_pkg::MODE_LOAD) &&
                      (int'(in_ch.coef_index) < iqdf_pkg::MAX_TAPS);
  assign out_load   = (state_q == S_FIN) && (!out_vld_q || out_ch.ready);
  assign acc_clr    = (state_q == S_REM) && rem_stat.done;

  // Configuration writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tap_cnt_q <= iqdf_pkg::TAP_COUNT_RST;
      dec_q     <= iqdf_pkg::DECIM_RST;
      spf_q     <= iqdf_pkg::FRAME_SIZE_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        iqdf_pkg::CFG_TAP_COUNT:  tap_cnt_q <= cfg_data_i[iqdf_pkg::TAP_CFG_W-1:0];
        iqdf_pkg::CFG_DECIM:      dec_q     <= cfg_data_i[iqdf_pkg::DEC_W-1:0];
        iqdf_pkg::CFG_FRAME_SIZE: spf_q     <= cfg_data_i[iqdf_pkg::SPF_W-1:0];
        default: ;
      endcase
    end
  end

  // Decimation phase check of the position that the sample arrives at.
  iqdf_rem u_rem (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (sample_acc),
    .dividend_i (pos_q),
    .divisor_i  (dec_eff),
    .stat_o     (rem_stat)
  );

  // Sequencer: item intake, sweep control and the output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      wr_ptr_q  <= '0;
      newest_q  <= '0;
      fill_q    <= '0;
      pos_q     <= '0;
      idx_q     <= '0;
      j_q       <= '0;
      d_q       <= '0;
      out_vld_q <= 1'b0;
    end else begin
      // The output valid flag is set by a load and cleared by its transfer.
      if (out_load) begin
        out_vld_q <= 1'b1;
      end else if (out_vld_q && out_ch.ready) begin
        out_vld_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (accept) begin
            case (in_ch.mode)
              iqdf_pkg::MODE_SAMPLE: begin
                newest_q <= wr_ptr_q;
                wr_ptr_q <= wr_ptr_q + 1'b1;
                if (int'(fill_q) < iqdf_pkg::MAX_TAPS) begin
                  fill_q <= fill_q + 1'b1;
                end
                if (int'(pos_inc) >= int'(spf_eff)) begin
                  pos_q <= '0;
                end else begin
                  pos_q <= pos_inc[iqdf_pkg::POS_W-1:0];
                end
                state_q <= S_REM;
              end
              iqdf_pkg::MODE_CLEAR: begin
                wr_ptr_q <= '0;
                fill_q   <= '0;
                pos_q    <= '0;
              end
              default: ;
            endcase
          end
        end
        S_REM: begin
          if (rem_stat.done) begin
            if (!rem_stat.zero) begin
              state_q <= S_IDLE;
            end else if (taps_eff == '0) begin
              state_q <= S_FIN;
            end else begin
              idx_q   <= newest_q - iqdf_pkg::TAP_AW'(taps_m1);
              j_q     <= '0;
              d_q     <= iqdf_pkg::TAP_AW'(taps_m1);
              state_q <= S_MAC;
            end
          end
        end
        S_MAC: begin
          idx_q <= idx_q + 1'b1;
          j_q   <= j_q + 1'b1;
          d_q   <= d_q - 1'b1;
          if (d_q == '0) begin
            state_q <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          if (!rd_vld_q && !mul_vld_q) begin
            state_q <= S_FIN;
          end
        end
        S_FIN: begin
          if (out_load) begin
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  // Result payload, loaded together with the output valid flag.
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_i_q <= round_sat(acc_i_q);
      out_q_q <= round_sat(acc_q_q);
    end
  end

  // Delay memory: one write at intake, one registered read per sweep cycle.
  always_ff @(posedge clk_i) begin
    if (sample_acc) begin
      dly_mem[wr_ptr_q] <= {in_ch.sample_q, in_ch.sample_i};
    end
    dly_rd_q <= dly_mem[idx_q];
  end

  // Coefficient memory: written in load mode, read in tap order.
  always_ff @(posedge clk_i) begin
    if (load_acc) begin
      coef_mem[iqdf_pkg::TAP_AW'(in_ch.coef_index)] <= in_ch.coef_value;
    end
    coef_rd_q <= coef_mem[j_q];
  end

  // Pipeline valid flags; a slot older than the fill count reads as zero.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_vld_q  <= 1'b0;
      rd_ok_q   <= 1'b0;
      mul_vld_q <= 1'b0;
    end else begin
      rd_vld_q  <= (state_q == S_MAC);
      rd_ok_q   <= ({1'b0, d_q} < fill_q);
      mul_vld_q <= rd_vld_q;
    end
  end

  // One multiplier per lane, then the accumulators.
  always_ff @(posedge clk_i) begin
    if (rd_ok_q) begin
      prod_i_q <= $signed(dly_rd_q[iqdf_pkg::SAMPLE_W-1:0]) * coef_rd_q;
      prod_q_q <= $signed(dly_rd_q[2*iqdf_pkg::SAMPLE_W-1:iqdf_pkg::SAMPLE_W]) * coef_rd_q;
    end else begin
      prod_i_q <= '0;
      prod_q_q <= '0;
    end
    if (acc_clr) begin
      acc_i_q <= '0;
      acc_q_q <= '0;
    end else if (mul_vld_q) begin
      acc_i_q <= acc_i_q + {{(iqdf_pkg::ACC_W-iqdf_pkg::PROD_W){prod_i_q[iqdf_pkg::PROD_W-1]}},
                            prod_i_q};
      acc_q_q <= acc_q_q + {{(iqdf_pkg::ACC_W-iqdf_pkg::PROD_W){prod_q_q[iqdf_pkg::PROD_W-1]}},
                            prod_q_q};
    end
  end

  // Channel outputs.
  assign in_ch.ready  = (state_q == S_IDLE);
  assign out_ch.valid = out_vld_q;
  assign out_ch.out_i = out_i_q;
  assign out_ch.out_q = out_q_q;

  // A result only appears after the final step of an item.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_vld_q) |-> $past(state_q == S_FIN))
    else $error("result raised outside the final step");

  // The remainder unit only finishes while the sequencer waits for it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rem_stat.done |-> (state_q == S_REM))
    else $error("phase check finished while not awaited");

  // The tap counters stay complementary across the sweep.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_MAC) |-> (({1'b0, j_q} + {1'b0, d_q}) == taps_m1))
    else $error("sweep counters out of step");

  // Products only flow while a sweep or its drain is in progress.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_vld_q |-> (state_q == S_MAC || state_q == S_DRAIN))
    else $error("product outside a sweep");

  // The fill count never passes the delay line depth.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    sample_acc |=> (int'(fill_q) <= iqdf_pkg::MAX_TAPS) && (fill_q != '0))
    else $error("fill count out of range after a sample");

endmodule

`default_nettype wire

@@ test/tb_iq_decimating_fir.sv @@
// Self-checking testbench for the decimating I/Q FIR filter.
`timescale 1ns / 1ps

module tb_iq_decimating_fir;

  localparam int     CYCLE_LIMIT = 2_000_000;
  localparam int     SETTLE_CYCLES = iqdf_pkg::MAX_TAPS + 40;
  localparam int     MAX_REPORTS = 10;
  localparam longint OUT_MAX = (64'sd1 <<< (iqdf_pkg::OUT_W - 1)) - 1;
  localparam longint OUT_MIN = -(64'sd1 <<< (iqdf_pkg::OUT_W - 1));
  localparam logic [iqdf_pkg::MODE_W-1:0] MODE_UNUSED = 2'd3;
  localparam logic signed [iqdf_pkg::COEF_W-1:0] COEF_MAX =
    {1'b0, {(iqdf_pkg::COEF_W-1){1'b1}}};
  localparam logic signed [iqdf_pkg::COEF_W-1:0] COEF_MIN =
    {1'b1, {(iqdf_pkg::COEF_W-1){1'b0}}};

  typedef struct {
    logic [iqdf_pkg::MODE_W-1:0]        mode;
    logic [iqdf_pkg::SAMPLE_W-1:0]      sample_i;
    logic [iqdf_pkg::SAMPLE_W-1:0]      sample_q;
    logic [iqdf_pkg::CIDX_W-1:0]        coef_index;
    logic signed [iqdf_pkg::COEF_W-1:0] coef_value;
  } fir_item_t;

  typedef struct packed {
    logic signed [iqdf_pkg::OUT_W-1:0] out_i;
    logic signed [iqdf_pkg::OUT_W-1:0] out_q;
  } iq_result_t;

  logic                            clk_i;
  logic                            rst_ni;
  logic                            cfg_we;
  logic [iqdf_pkg::CFG_IDX_W-1:0]  cfg_idx;
  logic [iqdf_pkg::CFG_DATA_W-1:0] cfg_data;

  iqdf_in_if  in_ch ();
  iqdf_out_if out_ch ();

  iq_decimating_fir i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .in_ch      (in_ch),
    .out_ch     (out_ch)
  );

  // Filter state as the predictor sees it.
  logic signed [iqdf_pkg::SAMPLE_W-1:0] delay_i [iqdf_pkg::MAX_TAPS];
  logic signed [iqdf_pkg::SAMPLE_W-1:0] delay_q [iqdf_pkg::MAX_TAPS];
  logic signed [iqdf_pkg::COEF_W-1:0]   coefs [iqdf_pkg::MAX_TAPS];
  int unsigned                          write_pos;
  int unsigned                          frame_pos;
  logic [iqdf_pkg::TAP_CFG_W-1:0]       tap_cfg;
  logic [iqdf_pkg::DEC_W-1:0]           dec_cfg;
  logic [iqdf_pkg::SPF_W-1:0]           spf_cfg;

  iq_result_t  expected_iq_q [$];
  int unsigned mismatches = 0;
  int unsigned cycle_cnt = 0;
  int          stall_left = 0;
  bit          gaps_on = 1'b1;

  // Clock.
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Cycle counter and timeout.
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
  end

  initial begin
    wait (cycle_cnt >= CYCLE_LIMIT);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Empties the delay lines and restarts the frame, as a clear item does.
  function automatic void clear_delay_lines();
    for (int k = 0; k < iqdf_pkg::MAX_TAPS; k++) begin
      delay_i[k] = '0;
      delay_q[k] = '0;
    end
    write_pos = 0;
    frame_pos = 0;
  endfunction

  // Rounds half up from Q1.17 products to input LSBs and saturates to 32 bits.
  function automatic logic signed [iqdf_pkg::OUT_W-1:0] round_saturate(input longint acc);
    longint scaled;
    scaled = (acc + (64'sd1 <<< (iqdf_pkg::COEF_W - 2))) >>> (iqdf_pkg::COEF_W - 1);
    if (scaled > OUT_MAX) scaled = OUT_MAX;
    if (scaled < OUT_MIN) scaled = OUT_MIN;
    return scaled[iqdf_pkg::OUT_W-1:0];
  endfunction

  // Updates the filter state for one accepted item and queues its result, if any.
  function automatic void fir_predict(input fir_item_t it);
    int unsigned taps;
    int unsigned dec;
    int unsigned spf;
    int unsigned idx;
    longint      acc_i;
    longint      acc_q;
    iq_result_t  res;
    case (it.mode)
      iqdf_pkg::MODE_LOAD: begin
        coefs[it.coef_index] = it.coef_value;
      end
      iqdf_pkg::MODE_CLEAR: begin
        clear_delay_lines();
      end
      iqdf_pkg::MODE_SAMPLE: begin
        delay_i[write_pos] = it.sample_i;
        delay_q[write_pos] = it.sample_q;
        taps = (tap_cfg > iqdf_pkg::MAX_TAPS) ? iqdf_pkg::MAX_TAPS : tap_cfg;
        dec = (dec_cfg == 0) ? 1 : dec_cfg;
        spf = (spf_cfg == 0) ? 1 : spf_cfg;
        if (spf > iqdf_pkg::MAX_FRAME) spf = iqdf_pkg::MAX_FRAME;
        if (frame_pos % dec == 0) begin
          // The oldest sample of the window meets the first coefficient.
          idx = (write_pos + iqdf_pkg::MAX_TAPS - ((taps == 0) ? 0 : taps - 1))
                % iqdf_pkg::MAX_TAPS;
          acc_i = 0;
          acc_q = 0;
          for (int j = 0; j < taps; j++) begin
            acc_i += longint'(delay_i[idx]) * longint'(coefs[j]);
            acc_q += longint'(delay_q[idx]) * longint'(coefs[j]);
            idx = (idx + 1) % iqdf_pkg::MAX_TAPS;
          end
          res.out_i = round_saturate(acc_i);
          res.out_q = round_saturate(acc_q);
          expected_iq_q.push_back(res);
        end
        write_pos = (write_pos + 1) % iqdf_pkg::MAX_TAPS;
        frame_pos = (frame_pos + 1 >= spf) ? 0 : frame_pos + 1;
      end
      default: begin
        // The unused mode leaves the block untouched.
      end
    endcase
  endfunction

  function automatic void flag_mismatch(input string what, input longint want,
                                        input longint got);
    mismatches++;
    if (mismatches <= MAX_REPORTS) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $realtime, what, want, got);
    end
  endfunction

  // Result checker: every output transfer is matched against the oldest expectation.
  always @(posedge clk_i) begin
    iq_result_t want;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (expected_iq_q.size() == 0) begin
        flag_mismatch("unexpected result, out_i", 0, out_ch.out_i);
      end else begin
        want = expected_iq_q.pop_front();
        if (out_ch.out_i !== want.out_i) flag_mismatch("out_i", want.out_i, out_ch.out_i);
        if (out_ch.out_q !== want.out_q) flag_mismatch("out_q", want.out_q, out_ch.out_q);
      end
    end
  end

  // Result receiver with random stall bursts.
  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      stall_left--;
    end else if (gaps_on && $urandom_range(5) == 0) begin
      stall_left = $urandom_range(5, 1);
    end
    out_ch.ready <= (stall_left == 0);
  end

  // Presents one item and holds it until its transfer; returns at a falling edge.
  task automatic send_item(input fir_item_t it);
    if (gaps_on && $urandom_range(3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(5, 1)) @(negedge clk_i);
    end
    in_ch.valid      <= 1'b1;
    in_ch.mode       <= it.mode;
    in_ch.sample_i   <= it.sample_i;
    in_ch.sample_q   <= it.sample_q;
    in_ch.coef_index <= it.coef_index;
    in_ch.coef_value <= it.coef_value;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    fir_predict(it);
    @(negedge clk_i);
  endtask

  function automatic fir_item_t make_item(input logic [iqdf_pkg::MODE_W-1:0] mode,
                                          input logic [iqdf_pkg::SAMPLE_W-1:0] si,
                                          input logic [iqdf_pkg::SAMPLE_W-1:0] sq);
    fir_item_t it;
    it.mode       = mode;
    it.sample_i   = si;
    it.sample_q   = sq;
    it.coef_index = iqdf_pkg::CIDX_W'($urandom);
    it.coef_value = iqdf_pkg::COEF_W'($urandom);
    return it;
  endfunction

  task automatic send_sample(input logic [iqdf_pkg::SAMPLE_W-1:0] si,
                             input logic [iqdf_pkg::SAMPLE_W-1:0] sq);
    send_item(make_item(iqdf_pkg::MODE_SAMPLE, si, sq));
  endtask

  task automatic send_coef(input int unsigned index,
                           input logic signed [iqdf_pkg::COEF_W-1:0] value);
    fir_item_t it;
    it = make_item(iqdf_pkg::MODE_LOAD, iqdf_pkg::SAMPLE_W'($urandom),
                   iqdf_pkg::SAMPLE_W'($urandom));
    it.coef_index = iqdf_pkg::CIDX_W'(index);
    it.coef_value = value;
    send_item(it);
  endtask

  task automatic send_random_samples(input int n);
    repeat (n) send_sample(iqdf_pkg::SAMPLE_W'($urandom), iqdf_pkg::SAMPLE_W'($urandom));
  endtask

  // Lowers valid and waits until the block has finished all outstanding work.
  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    while (expected_iq_q.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  // Writes all three registers on consecutive cycles; called only while idle.
  task automatic set_config(input int unsigned taps, input int unsigned dec,
                            input int unsigned spf);
    cfg_we   <= 1'b1;
    cfg_idx  <= iqdf_pkg::CFG_TAP_COUNT;
    cfg_data <= iqdf_pkg::CFG_DATA_W'(taps);
    @(negedge clk_i);
    cfg_idx  <= iqdf_pkg::CFG_DECIM;
    cfg_data <= iqdf_pkg::CFG_DATA_W'(dec);
    @(negedge clk_i);
    cfg_idx  <= iqdf_pkg::CFG_FRAME_SIZE;
    cfg_data <= iqdf_pkg::CFG_DATA_W'(spf);
    @(negedge clk_i);
    cfg_we   <= 1'b0;
    tap_cfg = iqdf_pkg::TAP_CFG_W'(taps);
    dec_cfg = iqdf_pkg::DEC_W'(dec);
    spf_cfg = iqdf_pkg::SPF_W'(spf);
  endtask

  // Fills the whole coefficient table so that no unwritten entry is ever read.
  task automatic test_coef_load();
    for (int k = 0; k < iqdf_pkg::MAX_TAPS; k++) begin
      if (k == 0) send_coef(k, COEF_MIN);
      else if (k == iqdf_pkg::MAX_TAPS - 1) send_coef(k, COEF_MAX);
      else send_coef(k, iqdf_pkg::COEF_W'($urandom));
    end
  endtask

  // Samples under the configuration left by reset.
  task automatic test_reset_defaults();
    send_random_samples(6);
  endtask

  // Full-scale samples against full-scale coefficients of both signs.
  task automatic test_sample_extremes();
    wait_idle();
    set_config(4, 1, 256);
    send_coef(0, COEF_MAX);
    send_coef(1, COEF_MIN);
    send_coef(2, COEF_MAX);
    send_coef(3, COEF_MIN);
    send_sample(24'h7fffff, 24'h800000);
    send_sample(24'h800000, 24'h7fffff);
    send_sample(24'h7fffff, 24'h800000);
    send_sample(24'h800000, 24'h7fffff);
    send_sample(24'h000000, 24'hffffff);
    send_sample(24'hffffff, 24'h000000);
  endtask

  // Unused mode, clear and a coefficient load in the middle of a stream.
  task automatic test_modes();
    send_item(make_item(MODE_UNUSED, iqdf_pkg::SAMPLE_W'($urandom),
                        iqdf_pkg::SAMPLE_W'($urandom)));
    send_item(make_item(iqdf_pkg::MODE_CLEAR, iqdf_pkg::SAMPLE_W'($urandom),
                        iqdf_pkg::SAMPLE_W'($urandom)));
    send_random_samples(2);
    send_coef(1, iqdf_pkg::COEF_W'($urandom));
    send_random_samples(1);
    send_item(make_item(iqdf_pkg::MODE_CLEAR, iqdf_pkg::SAMPLE_W'($urandom),
                        iqdf_pkg::SAMPLE_W'($urandom)));
    send_random_samples(1);
  endtask

  // Register corners: zero and oversized values, the largest legal values, short frames.
  task automatic test_config_corners();
    int unsigned corner [6][3] = '{'{0, 1, 256}, '{128, 0, 0}, '{255, 2, 1},
                                   '{1, 256, 4096}, '{3, 511, 8191}, '{6, 3, 5}};
    foreach (corner[n]) begin
      wait_idle();
      set_config(corner[n][0], corner[n][1], corner[n][2]);
      send_random_samples(6);
    end
    // A frame that shrinks below the current position wraps at the next sample.
    wait_idle();
    set_config(4, 1, 100);
    send_item(make_item(iqdf_pkg::MODE_CLEAR, iqdf_pkg::SAMPLE_W'($urandom),
                        iqdf_pkg::SAMPLE_W'($urandom)));
    send_random_samples(12);
    wait_idle();
    set_config(4, 2, 7);
    send_random_samples(6);
  endtask

  function automatic fir_item_t random_item();
    int unsigned pick;
    logic [iqdf_pkg::SAMPLE_W-1:0] rails [4] =
      '{24'h800000, 24'h7fffff, 24'h000000, 24'hffffff};
    logic [iqdf_pkg::SAMPLE_W-1:0] si;
    logic [iqdf_pkg::SAMPLE_W-1:0] sq;
    si = iqdf_pkg::SAMPLE_W'($urandom);
    sq = iqdf_pkg::SAMPLE_W'($urandom);
    pick = $urandom_range(99);
    if (pick < 82) return make_item(iqdf_pkg::MODE_SAMPLE, si, sq);
    if (pick < 88) return make_item(iqdf_pkg::MODE_LOAD, si, sq);
    if (pick < 92) return make_item(iqdf_pkg::MODE_CLEAR, si, sq);
    if (pick < 95) return make_item(MODE_UNUSED, si, sq);
    return make_item(iqdf_pkg::MODE_SAMPLE, rails[$urandom_range(3)],
                     rails[$urandom_range(3)]);
  endfunction

  // Random item mix under a fresh random configuration per phase.
  task automatic test_random(input int phases, input int items);
    int unsigned taps;
    int unsigned dec;
    int unsigned spf;
    repeat (phases) begin
      wait_idle();
      taps = ($urandom_range(3) == 0) ? $urandom_range(255) : $urandom_range(32, 1);
      dec  = ($urandom_range(4) == 0) ? $urandom_range(511) : $urandom_range(6);
      spf  = ($urandom_range(4) == 0) ? $urandom_range(8191) : $urandom_range(64);
      set_config(taps, dec, spf);
      repeat (items) send_item(random_item());
    end
  endtask

  // Back-to-back transfers with neither side pausing.
  task automatic test_steady_flow();
    wait_idle();
    gaps_on = 1'b0;
    test_random(1, 160);
  endtask

  initial begin
    in_ch.valid      = 1'b0;
    in_ch.mode       = iqdf_pkg::MODE_SAMPLE;
    in_ch.sample_i   = '0;
    in_ch.sample_q   = '0;
    in_ch.coef_index = '0;
    in_ch.coef_value = '0;
    cfg_we           = 1'b0;
    cfg_idx          = iqdf_pkg::CFG_TAP_COUNT;
    cfg_data         = '0;
    rst_ni           = 1'b0;
    clear_delay_lines();
    for (int k = 0; k < iqdf_pkg::MAX_TAPS; k++) coefs[k] = '0;
    tap_cfg = iqdf_pkg::TAP_COUNT_RST;
    dec_cfg = iqdf_pkg::DECIM_RST;
    spf_cfg = iqdf_pkg::FRAME_SIZE_RST;

    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_coef_load();
    test_reset_defaults();
    test_sample_extremes();
    test_modes();
    test_config_corners();
    test_random(8, 154);
    test_steady_flow();

    // Drain the remaining results, then give the block time for stray output.
    in_ch.valid <= 1'b0;
    while (expected_iq_q.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);

    if (mismatches == 0 && expected_iq_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
